@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// word widths, command and status codes, and the control word sent to the cells
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DATA_W           = 32;
   localparam int PRIO_W           = 16;
   localparam int OCC_W            = 5;
   localparam int DEFAULT_CAPACITY = 16;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // control broadcast to every cell of the row
   typedef struct packed {
      logic              insert;   // enqueue that is carried out
      logic              remove;   // dequeue that is carried out
      logic [PRIO_W-1:0] prio;     // priority of the new entry
      logic [DATA_W-1:0] data;     // data of the new entry
   } cell_ctrl_type;

endpackage

@@ src/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_top: stable sorted priority queue
// a row of cells kept in ascending priority order, equal priorities in fifo order
// ----------------------------------------------------------------------------
// usage
//  - req channel carries one command word: req_tuser selects enqueue or
//    dequeue, req_tdata holds the data word and its priority
//  - every accepted word gives exactly one rsp word: status in rsp_tuser,
//    removed data and occupancy after the command in rsp_tdata
//  - a smaller priority value is served first; an entry goes behind every
//    stored entry of equal or smaller priority
//  - all cells compare against the new priority in parallel and shift in the
//    same cycle: one word a cycle sustained while rsp is not stalled,
//    response in the cycle after acceptance (set by the single output register)
//  - dequeue on empty answers with an empty status, enqueue when full drops
//    the word and answers with a full status; neither changes the queue
//  - reset empties the queue (entry count to zero); slot contents are not
//    cleared, only slots below the count are ever read
//  - while rsp is stalled the output register holds its word and req_tready
//    drops, so no command is taken until the response is free
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // item_data [31:0], item_priority [47:32]
   input  logic [0:0]  req_tuser,   // command [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // head_data [31:0], occupancy [36:32], zero fill
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int OCC_X_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

   // input unpacking
   cmd_type           req_cmd;
   logic [DATA_W-1:0] req_data;
   logic [PRIO_W-1:0] req_prio;
   logic              req_fire;

   assign req_cmd  = cmd_type'(req_tuser[0]);
   assign req_data = req_tdata[DATA_W-1:0];
   assign req_prio = req_tdata[DATA_W +: PRIO_W];

   // queue state
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              is_full, is_empty;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_head_ff, rsp_head_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [OCC_X_W-1:0] rsp_count_x;

   // cell row
   cell_ctrl_type     ctrl;
   logic              cell_keep [CAPACITY];
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [PRIO_W-1:0] cell_prio [CAPACITY];

   // new command only when the output register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   assign ctrl.insert = req_fire && (req_cmd == CMD_ENQUEUE) && !is_full;
   assign ctrl.remove = req_fire && (req_cmd == CMD_DEQUEUE) && !is_empty;
   assign ctrl.prio   = req_prio;
   assign ctrl.data   = req_data;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              occupied;
      logic              left_keep;
      logic [DATA_W-1:0] left_data, right_data;
      logic [PRIO_W-1:0] left_prio, right_prio;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         // head cell: nothing ahead, so a non-kept head takes the new entry
         assign left_keep = 1'b1;
         assign left_data = ctrl.data;
         assign left_prio = ctrl.prio;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_data = cell_data[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // tail cell has no right neighbour; its contents fall out of the count
         assign right_data = cell_data[i];
         assign right_prio = cell_prio[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .left_keep  (left_keep),
         .left_data  (left_data),
         .left_prio  (left_prio),
         .right_data (right_data),
         .right_prio (right_prio),
         .keep       (cell_keep[i]),
         .data       (cell_data[i]),
         .prio       (cell_prio[i])
      );
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   // response word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_head_in  = '0;
         rsp_count_in = count_in;
         case (req_cmd)
            CMD_ENQUEUE: begin
               rsp_status_in = is_full ? ST_FULL : ST_ENQUEUED;
            end
            CMD_DEQUEUE: begin
               if (is_empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  rsp_status_in = ST_DEQUEUED;
                  rsp_head_in   = cell_data[0];
               end
            end
            default: begin
               rsp_status_in = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_head_ff   <= rsp_head_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // occupancy shows the low bits of the count
   assign rsp_count_x = OCC_X_W'(rsp_count_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_x[OCC_W-1:0], rsp_head_ff};
   assign rsp_tuser  = rsp_status_ff;

   // count never runs past the number of cells
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   // a carried-out dequeue lowers the count by one
   a_dequeue_count : assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("dequeue did not lower the count");

   // an enqueue while full reports full and leaves the count alone
   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_ENQUEUE && is_full)
      |=> (rsp_status_ff == ST_FULL) && $stable(count_ff))
      else $error("enqueue when full not dropped");

   // the response to an accepted command reports the entry count after it
   a_rsp_count : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff && (rsp_count_ff == count_ff))
      else $error("response occupancy differs from entry count");

endmodule

@@ src/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// holds one entry, keeps it, takes the new entry or its neighbour's on insert,
// and takes its right neighbour's entry on remove
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                occupied,
   input  logic                left_keep,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [PRIO_W-1:0]   left_prio,
   input  logic [DATA_W-1:0]   right_data,
   input  logic [PRIO_W-1:0]   right_prio,
   output logic                keep,
   output logic [DATA_W-1:0]   data,
   output logic [PRIO_W-1:0]   prio
);

   logic [DATA_W-1:0] data_ff, data_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;

   // entry stays put when it is served no later than the new one
   assign keep = occupied && (prio_ff <= ctrl.prio);

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            if (left_keep) begin
               data_in = ctrl.data;
               prio_in = ctrl.prio;
            end else begin
               data_in = left_data;
               prio_in = left_prio;
            end
         end
      end else if (ctrl.remove) begin
         data_in = right_data;
         prio_in = right_prio;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign data = data_ff;
   assign prio = prio_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue_top
// drives enqueue and dequeue words with random gaps and response stalls, keeps
// its own sorted copy of the queue and checks every response word against it
// ----------------------------------------------------------------------------
module testbench;
   import spq_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_WORDS = 925;
   localparam int HOLD_CYCLES  = 120;    // long response back-pressure stretch
   localparam int STUCK_LIMIT  = 1000;   // cycles with no handshake before giving up

   // one command word as offered on the req channel
   typedef struct {
      cmd_type           cmd;
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } queue_cmd_type;

   // one response word as expected on the rsp channel
   typedef struct {
      logic [DATA_W-1:0] head;
      status_type        status;
      logic [OCC_W-1:0]  occ;
   } queue_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // item_data [31:0], item_priority [47:32]
   logic [0:0]  req_tuser = '0;    // command [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // head_data [31:0], occupancy [36:32], zero fill
   logic [1:0]  rsp_tuser;         // status [1:0]

   // words waiting to be sent, and responses still owed by the block
   queue_cmd_type pending_words[$];
   queue_rsp_type expected_rsps[$];

   // private copy of the sorted queue, slot 0 is the head
   logic [DATA_W-1:0] queue_data [CAPACITY];
   logic [PRIO_W-1:0] queue_prio [CAPACITY];
   int                queue_count = 0;

   int          error_count = 0;
   int          stuck_cycles = 0;
   bit          req_fire = 1'b0;      // req word taken at the last rising edge
   bit          hold_request = 1'b0;  // asks the receiver for one long hold-off
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned recv_stall = 0;
   int unsigned recv_calm = 0;

   sorted_priority_queue_top #(.CAPACITY(CAPACITY)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // applies one command to the private queue and returns the response it owes
   function automatic queue_rsp_type apply_command(queue_cmd_type c);
      queue_rsp_type r;
      int            pos;
      r.head   = '0;
      r.status = ST_ENQUEUED;
      if (c.cmd == CMD_ENQUEUE) begin
         if (queue_count >= CAPACITY) begin
            r.status = ST_FULL;   // dropped, queue untouched
         end else begin
            // stable insert: behind every entry of equal or smaller priority
            pos = 0;
            while (pos < queue_count && queue_prio[pos] <= c.prio) pos++;
            for (int i = queue_count; i > pos; i--) begin
               queue_data[i] = queue_data[i-1];
               queue_prio[i] = queue_prio[i-1];
            end
            queue_data[pos] = c.data;
            queue_prio[pos] = c.prio;
            queue_count++;
         end
      end else begin
         if (queue_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.head   = queue_data[0];
            r.status = ST_DEQUEUED;
            for (int i = 1; i < queue_count; i++) begin
               queue_data[i-1] = queue_data[i];
               queue_prio[i-1] = queue_prio[i];
            end
            queue_count--;
         end
      end
      r.occ = queue_count[OCC_W-1:0];
      return r;
   endfunction

   // idle length for either side: mostly none, some short, a few long,
   // now and then a calm stretch with no idling at all
   task automatic pick_pause(inout int unsigned calm, output int unsigned pause);
      int unsigned roll;
      pause = 0;
      if (calm > 0) begin
         calm--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 3) calm = $urandom_range(20, 60);
         else if (roll >= 90) pause = $urandom_range(6, 25);
         else if (roll >= 60) pause = $urandom_range(1, 3);
      end
   endtask

   // random command; enq_pct steers the fill level up or down
   function automatic queue_cmd_type random_command(int unsigned enq_pct);
      queue_cmd_type c;
      c.cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
      c.data = $urandom;
      case ($urandom_range(0, 4))
         0: c.prio = PRIO_W'($urandom_range(0, 3));            // lots of ties
         1: c.prio = $urandom_range(0, 1) ? '1 : '0;           // extremes
         2: c.prio = PRIO_W'($urandom_range(16'h7FFE, 16'h8001));
         default: c.prio = PRIO_W'($urandom);
      endcase
      if ($urandom_range(0, 19) == 0)
         c.data = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      return c;
   endfunction

   // monitor: sample both handshakes at the rising edge, predict and check
   always @(posedge clock) begin : monitor
      queue_rsp_type got;
      queue_rsp_type want;
      queue_cmd_type taken;
      if (!reset) begin
         req_fire = req_tvalid && req_tready;
         // response first: it always belongs to an earlier command word
         if (rsp_tvalid && rsp_tready) begin
            got.head   = rsp_tdata[31:0];
            got.occ    = rsp_tdata[36:32];
            got.status = status_type'(rsp_tuser);
            if (expected_rsps.size() == 0) begin
               $error("unexpected response word: head_data %h status %0d occupancy %0d",
                      got.head, got.status, got.occ);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.head !== want.head) begin
                  $error("head_data mismatch: expected %h, actual %h", want.head, got.head);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                  error_count++;
               end
               if (got.occ !== want.occ) begin
                  $error("occupancy mismatch: expected %0d, actual %0d", want.occ, got.occ);
                  error_count++;
               end
            end
         end
         if (req_fire) begin
            taken.cmd  = cmd_type'(req_tuser[0]);
            taken.data = req_tdata[31:0];
            taken.prio = req_tdata[47:32];
            expected_rsps.push_back(apply_command(taken));
         end
         // watchdog: only counts while something is still in flight
         if (req_fire || (rsp_tvalid && rsp_tready)) begin
            stuck_cycles = 0;
         end else if (pending_words.size() != 0 || req_tvalid || expected_rsps.size() != 0) begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   // driver: offers the next pending word at the falling edge, with gaps
   always @(negedge clock) begin : driver
      queue_cmd_type next_word;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            next_word = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {next_word.prio, next_word.data};
            req_tuser  <= next_word.cmd;
            pick_pause(send_calm, send_gap);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request so the
   // output register stays full and req_tready drops while words keep coming
   always @(negedge clock) begin : receiver
      int unsigned pause;
      if (!reset) begin
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            recv_stall   = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else begin
            pick_pause(recv_calm, pause);
            if (pause > 0) begin
               recv_stall = pause - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      queue_cmd_type c;
      int            sent;
      int unsigned   burst;
      int unsigned   enq_pct;
      // directed: empty dequeue, fill with extremes and ties, drop when full
      c.cmd = CMD_DEQUEUE; c.data = 32'hFFFF_FFFF; c.prio = '1;
      pending_words.push_back(c);
      for (int i = 0; i < CAPACITY; i++) begin
         c.cmd = CMD_ENQUEUE;
         case (i % 4)
            0: c.data = 32'h7FFF_FFFF;
            1: c.data = 32'h8000_0000;
            2: c.data = 32'h0000_0000;
            default: c.data = 32'hFFFF_FFFF;
         endcase
         case (i % 5)
            0: c.prio = '0;
            1: c.prio = '1;
            2: c.prio = 16'h8000;
            3: c.prio = '0;        // tie with an earlier entry, must stay behind it
            default: c.prio = 16'h7FFF;
         endcase
         if (i >= 8) c.data = c.data ^ i;
         pending_words.push_back(c);
      end
      c.cmd = CMD_ENQUEUE; c.data = 32'h1234_5678; c.prio = '0;   // full: dropped
      pending_words.push_back(c);
      for (int i = 0; i < 6; i++) begin
         c.cmd = CMD_DEQUEUE; c.data = $urandom; c.prio = PRIO_W'($urandom);
         pending_words.push_back(c);
      end

      // random: bursts that lean towards filling, draining or neither,
      // so the queue swings between full and empty many times
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(10, 40);
         case ($urandom_range(0, 2))
            0: enq_pct = 85;
            1: enq_pct = 50;
            default: enq_pct = 15;
         endcase
         for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
            pending_words.push_back(random_command(enq_pct));
            sent++;
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // long hold-off in mid-run while plenty of words are still queued
      while (pending_words.size() > 500) @(posedge clock);
      hold_request = 1'b1;

      // drain: everything sent and answered, then a few cycles for stray words
      while (pending_words.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_top.sv
tb/testbench.sv
